// File: design/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and constants for the duplicate removal block
// Default sizes, fixed field widths and the link word passed between cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

   localparam int STORE_DEPTH_DEF = 64;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int ITEM_W          = 32;
   localparam int COUNT_OUT_W     = 7;

   // control word travelling down the cell chain with each value
   typedef struct packed {
      logic valid;
      logic hit;
   } link_type;

endpackage

`default_nettype wire

// File: design/sdr_req_if.sv
// ----------------------------------------------------------------------------
// sdr_req_if: input channel
// Valid/ready channel carrying one array element and its start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdr_req_if;
   import sdr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ITEM_W-1:0] item_value;
   logic              starts_array;

   modport source (output valid, output item_value, output starts_array, input ready);
   modport sink   (input valid, input item_value, input starts_array, output ready);

endinterface

`default_nettype wire

// File: design/sdr_rsp_if.sv
// ----------------------------------------------------------------------------
// sdr_rsp_if: result channel
// Valid/ready channel carrying the element, its first-seen and overflow flags
// and the running unique count.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdr_rsp_if;
   import sdr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ITEM_W-1:0]      out_value;
   logic                   is_first_seen;
   logic [COUNT_OUT_W-1:0] unique_count;
   logic                   store_overflow;

   modport source (output valid, output out_value, output is_first_seen,
                   output unique_count, output store_overflow, input ready);
   modport sink   (input valid, input out_value, input is_first_seen,
                   input unique_count, input store_overflow, output ready);

endinterface

`default_nettype wire

// File: design/sdr_cell.sv
// ----------------------------------------------------------------------------
// sdr_cell: one store cell of the compare chain
// Holds one kept value, compares the passing value against it and hands the
// value and the accumulated hit flag to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_cell #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_W     = 7,
   parameter int CELL_INDEX  = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sdr_pkg::link_type      link_i,
   input  wire logic [VALUE_WIDTH-1:0] value_i,
   output sdr_pkg::link_type           link_o,
   output logic      [VALUE_WIDTH-1:0] value_o,
   input  wire logic [COUNT_W-1:0]     count_i,
   input  wire logic                   wr_en_i,
   input  wire logic [VALUE_WIDTH-1:0] wr_data_i
);
   import sdr_pkg::*;

   localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(CELL_INDEX);

   logic [VALUE_WIDTH-1:0] stored_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   link_type               link_ff;
   link_type               link_in;
   logic                   match;

   // only cells below the kept count hold a value of this array
   assign match = (MY_INDEX < count_i) && (stored_ff == value_i);

   always_comb begin
      link_in.valid = link_i.valid;
      link_in.hit   = link_i.hit | match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_i;
      if (wr_en_i && (count_i == MY_INDEX)) begin
         stored_ff <= wr_data_i;
      end
   end

   assign link_o  = link_ff;
   assign value_o = value_ff;

endmodule

`default_nettype wire

// File: design/stable_duplicate_removal.sv
// ----------------------------------------------------------------------------
// stable_duplicate_removal: order-preserving duplicate removal
// Each element is checked against the unique values kept for the current
// array; new values are appended and flagged, repeats are flagged as such.
// ----------------------------------------------------------------------------
// usage:
//   req carries one element per word plus starts_array, which empties the
//   store before that element. rsp returns one word per element: the element,
//   is_first_seen, the unique count after it and store_overflow when a new
//   value finds the store full.
//   the element walks a chain of STORE_DEPTH cells, one cell per cycle, each
//   comparing it against its kept value. a word passes the entry register,
//   the cells, the pending register and the result register; req is taken
//   again once the result is registered, so a new word is not accepted
//   before the last one has left the chain.
//   reset empties the store (count zero) and drops any word in flight.
//   while rsp is stalled the result holds; one more word may be accepted and
//   walks the chain, then waits until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_duplicate_removal #(
   parameter int STORE_DEPTH = sdr_pkg::STORE_DEPTH_DEF,
   parameter int VALUE_WIDTH = sdr_pkg::VALUE_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   sdr_req_if.sink   req,
   sdr_rsp_if.source rsp
);
   import sdr_pkg::*;

   localparam int                 COUNT_W = $clog2(STORE_DEPTH + 1);
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(STORE_DEPTH);

   logic                          accept;
   logic [VALUE_WIDTH+ITEM_W-1:0] item_ext;
   logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;

   logic                   busy_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   logic [ITEM_W-1:0]      item_ff;
   logic                   entry_valid_ff;
   logic [VALUE_WIDTH-1:0] entry_value_ff;
   logic                   pend_valid_ff;
   logic                   pend_hit_ff;
   logic [VALUE_WIDTH-1:0] pend_value_ff;
   logic                   finalize;
   logic                   wr_en;

   logic                   rsp_valid_ff;
   logic [ITEM_W-1:0]      rsp_value_ff;
   logic                   rsp_first_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                   rsp_overflow_ff;

   link_type               link    [STORE_DEPTH+1];
   logic [VALUE_WIDTH-1:0] value_w [STORE_DEPTH+1];

   assign accept    = req.valid && req.ready;
   assign req.ready = !busy_ff;
   assign item_ext  = {{VALUE_WIDTH{1'b0}}, req.item_value};

   assign finalize = pend_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign wr_en    = finalize && !pend_hit_ff && (count_ff != DEPTH_C);

   always_comb begin
      count_in = count_ff;
      if (accept && req.starts_array) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_in};

   // cell chain
   always_comb begin
      link[0].valid = entry_valid_ff;
      link[0].hit   = 1'b0;
      value_w[0]    = entry_value_ff;
   end

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      sdr_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .COUNT_W     (COUNT_W),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .link_i    (link[i]),
         .value_i   (value_w[i]),
         .link_o    (link[i+1]),
         .value_o   (value_w[i+1]),
         .count_i   (count_ff),
         .wr_en_i   (wr_en),
         .wr_data_i (pend_value_ff)
      );
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         count_ff        <= '0;
         entry_valid_ff  <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         count_ff       <= count_in;
         entry_valid_ff <= accept;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (finalize) begin
            busy_ff <= 1'b0;
         end
         if (link[STORE_DEPTH].valid) begin
            pend_valid_ff <= 1'b1;
         end else if (finalize) begin
            pend_valid_ff <= 1'b0;
         end
         if (finalize) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff        <= req.item_value;
         entry_value_ff <= item_ext[VALUE_WIDTH-1:0];
      end
      if (link[STORE_DEPTH].valid) begin
         pend_hit_ff   <= link[STORE_DEPTH].hit;
         pend_value_ff <= value_w[STORE_DEPTH];
      end
      if (finalize) begin
         rsp_value_ff    <= item_ff;
         rsp_first_ff    <= wr_en;
         rsp_overflow_ff <= !pend_hit_ff && (count_ff == DEPTH_C);
         rsp_count_ff    <= count_ext[COUNT_OUT_W-1:0];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_value      = rsp_value_ff;
   assign rsp.is_first_seen  = rsp_first_ff;
   assign rsp.unique_count   = rsp_count_ff;
   assign rsp.store_overflow = rsp_overflow_ff;

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("kept count above store depth");

   a_one_token : assert property (@(posedge clock) disable iff (reset)
      !(entry_valid_ff && pend_valid_ff))
      else $error("two words in flight");

   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid_ff && rsp_first_ff && rsp_overflow_ff))
      else $error("first seen and overflow together");

   a_start_clear : assert property (@(posedge clock) disable iff (reset)
      accept && req.starts_array |=> count_ff == '0)
      else $error("start of array did not empty the store");

endmodule

`default_nettype wire

// File: bench/tb_stable_duplicate_removal.sv
// ----------------------------------------------------------------------------
// tb_stable_duplicate_removal: self-checking bench for duplicate removal
// Drives arrays of signed words with start marks through req, predicts the
// first-seen flag, running unique count and overflow flag of every word,
// and checks each rsp word in order against the prediction. Both channels
// idle at random, with bursts of back-to-back traffic.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
   logic [sdr_pkg::ITEM_W-1:0]      value;
   logic                            first_seen;
   logic [sdr_pkg::COUNT_OUT_W-1:0] count;
   logic                            overflow;
} verdict_type;

class dedup_scoreboard;

   localparam int DEPTH = sdr_pkg::STORE_DEPTH_DEF;
   localparam int VW    = sdr_pkg::VALUE_WIDTH_DEF;

   logic [VW-1:0] kept_values [DEPTH];
   int unsigned   kept_total;
   verdict_type   expected_verdicts [$];
   int unsigned   mismatches;

   function new();
      kept_total = 0;
      mismatches = 0;
   endfunction

   function void record_element(logic [sdr_pkg::ITEM_W-1:0] value, logic start);
      verdict_type want;
      bit          seen;
      if (start) begin
         kept_total = 0;
      end
      seen = 1'b0;
      for (int i = 0; i < kept_total; i++) begin
         if (kept_values[i] == value[VW-1:0]) begin
            seen = 1'b1;
         end
      end
      want.value      = value;
      want.first_seen = 1'b0;
      want.overflow   = 1'b0;
      if (!seen) begin
         if (kept_total < DEPTH) begin
            kept_values[kept_total] = value[VW-1:0];
            kept_total++;
            want.first_seen = 1'b1;
         end else begin
            want.overflow = 1'b1;
         end
      end
      want.count = kept_total[sdr_pkg::COUNT_OUT_W-1:0];
      expected_verdicts.push_back(want);
   endfunction

   function void check_result(verdict_type got);
      verdict_type want;
      if (expected_verdicts.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("rsp word with nothing expected: value %h first %b count %0d ovf %b",
                     got.value, got.first_seen, got.count, got.overflow);
         end
      end else begin
         want = expected_verdicts.pop_front();
         if (got.value !== want.value || got.first_seen !== want.first_seen ||
             got.count !== want.count || got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("rsp mismatch: expected value %h first %b count %0d ovf %b",
                        want.value, want.first_seen, want.count, want.overflow);
               $display("              got      value %h first %b count %0d ovf %b",
                        got.value, got.first_seen, got.count, got.overflow);
            end
         end
      end
   endfunction

   function int pending();
      return expected_verdicts.size();
   endfunction

endclass

module tb_stable_duplicate_removal;

   localparam int DEPTH       = sdr_pkg::STORE_DEPTH_DEF;
   localparam int VW          = sdr_pkg::VALUE_WIDTH_DEF;
   localparam int ITEM_TARGET = 1650;

   logic clock = 1'b0;
   logic reset;

   sdr_req_if req_ch ();
   sdr_rsp_if rsp_ch ();

   dedup_scoreboard dedup_board = new();

   int unsigned words_sent  = 0;
   int unsigned send_burst  = 0;
   int unsigned drain_burst = 0;

   stable_duplicate_removal #(
      .STORE_DEPTH (DEPTH),
      .VALUE_WIDTH (VW)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // entered and left at a falling edge
   task automatic send_word(input logic [sdr_pkg::ITEM_W-1:0] value, input logic start);
      int gap;
      if (send_burst > 0) begin
         send_burst--;
         gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         send_burst = $urandom_range(10, 60);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 16);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.item_value   <= value;
      req_ch.starts_array <= start;
      do @(posedge clock); while (!req_ch.ready);
      dedup_board.record_element(value, start);
      words_sent++;
      @(negedge clock);
   endtask

   // hold off the sender until every word has come back
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (dedup_board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [sdr_pkg::ITEM_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return 32'h0000_0000;
               3:       return 32'hffff_ffff;
               default: return 32'h0000_0001;
            endcase
         end
         1:       return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random_arrays();
      logic [sdr_pkg::ITEM_W-1:0] pool [$];
      int   len;
      int   pool_size;
      int   next_new;
      int   pick;
      int   arrays;
      bit   long_run;
      logic start;
      arrays = 0;
      while (words_sent < ITEM_TARGET) begin
         long_run  = ($urandom_range(0, 3) == 0);
         len       = long_run ? $urandom_range(60, 100) : $urandom_range(1, 20);
         pool_size = long_run ? $urandom_range(50, 80) : $urandom_range(1, len);
         pool.delete();
         repeat (pool_size) pool.push_back(pick_value());
         next_new = 0;
         for (int j = 0; j < len && words_sent < ITEM_TARGET; j++) begin
            if (next_new < pool_size &&
                (j == 0 || $urandom_range(0, 3) < (long_run ? 3 : 2))) begin
               pick = next_new;
               next_new++;
            end else begin
               pick = $urandom_range(0, next_new - 1);
            end
            // occasional array with no start mark, or a stray one mid-array
            if (j == 0) begin
               start = ($urandom_range(0, 9) != 0);
            end else begin
               start = ($urandom_range(0, 49) == 0);
            end
            send_word(pool[pick], start);
         end
         arrays++;
         if (arrays % 8 == 0) begin
            wait_for_drain();
         end
      end
   endtask

   initial begin : stimulus
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.item_value   = '0;
      req_ch.starts_array = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // array that begins at reset, no start mark
      send_word(32'h0000_0005, 1'b0);
      send_word(32'h0000_0005, 1'b0);
      // extremes and repeats
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h7fff_ffff, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hffff_ffff, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'hffff_ffff, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'hffff_fffe, 1'b0);
      send_word(32'h0000_0005, 1'b0);
      // restart forgets earlier values
      send_word(32'h7fff_ffff, 1'b1);
      send_word(32'h7fff_ffff, 1'b1);
      send_word(32'h5555_5555, 1'b0);
      send_word(32'haaaa_aaaa, 1'b0);
      send_word(32'h5555_5555, 1'b0);
      send_word(32'h7fff_ffff, 1'b0);
      wait_for_drain();

      run_random_arrays();

      req_ch.valid <= 1'b0;
      while (dedup_board.pending() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (dedup_board.mismatches == 0 && dedup_board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : rsp_side
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (drain_burst > 0) begin
            drain_burst--;
            stall = 0;
         end else if ($urandom_range(0, 9) == 0) begin
            drain_burst = $urandom_range(10, 60);
            stall = 0;
         end else begin
            stall = $urandom_range(0, 16);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && !reset));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      verdict_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.value      = rsp_ch.out_value;
         got.first_seen = rsp_ch.is_first_seen;
         got.count      = rsp_ch.unique_count;
         got.overflow   = rsp_ch.store_overflow;
         dedup_board.check_result(got);
      end
   end

   initial begin : watchdog
      #12_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
design/sdr_pkg.sv
design/sdr_req_if.sv
design/sdr_rsp_if.sv
design/sdr_cell.sv
design/stable_duplicate_removal.sv
bench/tb_stable_duplicate_removal.sv
